@@ hw/rtl/fsmc_pkg.sv @@
// ---------------------------------------------------------------------------
// fsmc_pkg
// Types, constants and the micro-op table of the 16-bit Forth stack machine.
// ---------------------------------------------------------------------------
`default_nettype none

package fsmc_pkg;

   localparam int unsigned MEM_WORDS_DEF = 8192;

   localparam logic [15:0] CELL_SP0 = 16'd6;
   localparam logic [15:0] CELL_RP0 = 16'd7;
   localparam logic [15:0] CELL_SP  = 16'd33;
   localparam logic [15:0] CELL_RP  = 16'd34;
   localparam logic [15:0] ALL_ONES = 16'hFFFF;
   localparam logic [15:0] SIGN_BIT = 16'h8000;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_START = 2'd2,
      OP_STEP  = 2'd3
   } op_type;

   localparam logic [1:0] RUN_IDLE = 2'd0;
   localparam logic [1:0] RUN_GO   = 2'd1;
   localparam logic [1:0] RUN_HALT = 2'd2;
   localparam logic [1:0] RUN_END  = 2'd3;

   // instruction classes: opcodes 0..20, then call and start
   localparam logic [4:0] OPC_NOP    = 5'd0;
   localparam logic [4:0] OPC_HALT   = 5'd1;
   localparam logic [4:0] OPC_LIT    = 5'd2;
   localparam logic [4:0] OPC_EXIT   = 5'd3;
   localparam logic [4:0] OPC_LOAD   = 5'd4;
   localparam logic [4:0] OPC_STORE  = 5'd5;
   localparam logic [4:0] OPC_DROP   = 5'd6;
   localparam logic [4:0] OPC_OVER   = 5'd7;
   localparam logic [4:0] OPC_SWAP   = 5'd8;
   localparam logic [4:0] OPC_DUP    = 5'd9;
   localparam logic [4:0] OPC_UMPLUS = 5'd10;
   localparam logic [4:0] OPC_NAND   = 5'd11;
   localparam logic [4:0] OPC_ZLESS  = 5'd12;
   localparam logic [4:0] OPC_TOR    = 5'd13;
   localparam logic [4:0] OPC_RFROM  = 5'd14;
   localparam logic [4:0] OPC_NEXT   = 5'd15;
   localparam logic [4:0] OPC_BRANCH = 5'd16;
   localparam logic [4:0] OPC_ZBR    = 5'd17;
   localparam logic [4:0] OPC_EXEC   = 5'd18;
   localparam logic [4:0] OPC_TX     = 5'd19;
   localparam logic [4:0] OPC_RX     = 5'd20;
   localparam logic [4:0] CLS_CALL   = 5'd21;
   localparam logic [4:0] CLS_START  = 5'd22;

   typedef struct packed {
      logic [1:0]  operation;
      logic [12:0] address;
      logic [15:0] write_value;
      logic [7:0]  rx_byte;
      logic        rx_eof;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic [1:0]  run_state;
      logic [15:0] program_counter;
   } rsp_type;

   typedef struct packed {
      logic        en;
      logic        we;
      logic [15:0] addr;
      logic [15:0] wdata;
   } mem_req_type;

   typedef struct packed {
      logic        go;
      logic        rs;
      logic        pop;
      logic [15:0] value;
   } stk_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] data;
   } stk_rsp_type;

   typedef enum logic [2:0] {
      M_IDLE, M_READ, M_FETCH, M_DECODE, M_UOP, M_STKW, M_RDW, M_DONE
   } main_state_type;

   typedef enum logic [2:0] {
      S_IDLE, S_P1, S_P2, S_P3, S_P4
   } stk_state_type;

   typedef enum logic [3:0] {
      K_END, K_PUSHD, K_PUSHR, K_POPD, K_POPR, K_RDOP, K_LOAD, K_STORE,
      K_CPSP, K_CPRP
   } uop_kind_type;

   typedef enum logic [3:0] {
      SRC_A, SRC_B, SRC_T, SRC_W, SRC_SUMLO, SRC_SUMHI, SRC_NAND, SRC_SIGN,
      SRC_RX, SRC_ONES, SRC_PC1, SRC_DEC, SRC_MEMW
   } src_type;

   typedef enum logic [2:0] {
      PS_PC1, PS_PC2, PS_A, PS_T, PS_HALT, PS_NEXT, PS_ZB, PS_START
   } pcsel_type;

   typedef struct packed {
      uop_kind_type kind;
      src_type      src;
      logic         dst_b;
      logic         cond_nz;
      pcsel_type    pcsel;
      logic         tx;
   } uop_type;

   function automatic logic [4:0] opc_class(logic [15:0] w);
      return (w < 16'd21) ? w[4:0] : CLS_CALL;
   endfunction

   function automatic uop_type mk(uop_kind_type k, src_type s, logic db, logic c,
                                  pcsel_type p, logic tx);
      uop_type u;
      u.kind    = k;
      u.src     = s;
      u.dst_b   = db;
      u.cond_nz = c;
      u.pcsel   = p;
      u.tx      = tx;
      return u;
   endfunction

   function automatic uop_type pushd(src_type s);
      return mk(K_PUSHD, s, 1'b0, 1'b0, PS_PC1, 1'b0);
   endfunction

   function automatic uop_type pushr(src_type s);
      return mk(K_PUSHR, s, 1'b0, 1'b0, PS_PC1, 1'b0);
   endfunction

   function automatic uop_type popd(logic db);
      return mk(K_POPD, SRC_A, db, 1'b0, PS_PC1, 1'b0);
   endfunction

   function automatic uop_type popr();
      return mk(K_POPR, SRC_A, 1'b0, 1'b0, PS_PC1, 1'b0);
   endfunction

   function automatic uop_type endp(pcsel_type p);
      return mk(K_END, SRC_A, 1'b0, 1'b0, p, 1'b0);
   endfunction

   function automatic uop_type simple(uop_kind_type k);
      return mk(k, SRC_A, 1'b0, 1'b0, PS_PC1, 1'b0);
   endfunction

   // micro-program of each class, step by step
   function automatic uop_type uop_at(logic [4:0] cls, logic [2:0] idx);
      uop_type prog [8];
      for (int i = 0; i < 8; i++) begin
         prog[i] = endp(PS_PC1);
      end
      case (cls)
         OPC_NOP: begin
         end
         OPC_HALT: begin
            prog[0] = endp(PS_HALT);
         end
         OPC_LIT: begin
            prog[0] = simple(K_RDOP);
            prog[1] = pushd(SRC_T);
            prog[2] = endp(PS_PC2);
         end
         OPC_EXIT: begin
            prog[0] = popr();
            prog[1] = endp(PS_A);
         end
         OPC_LOAD: begin
            prog[0] = popd(1'b0);
            prog[1] = simple(K_LOAD);
            prog[2] = pushd(SRC_A);
         end
         OPC_STORE: begin
            prog[0] = popd(1'b0);
            prog[1] = popd(1'b1);
            prog[2] = simple(K_STORE);
         end
         OPC_DROP: begin
            prog[0] = popd(1'b0);
         end
         OPC_OVER: begin
            prog[0] = popd(1'b0);
            prog[1] = popd(1'b1);
            prog[2] = pushd(SRC_B);
            prog[3] = pushd(SRC_A);
            prog[4] = pushd(SRC_B);
         end
         OPC_SWAP: begin
            prog[0] = popd(1'b0);
            prog[1] = popd(1'b1);
            prog[2] = pushd(SRC_A);
            prog[3] = pushd(SRC_B);
         end
         OPC_DUP: begin
            prog[0] = popd(1'b0);
            prog[1] = pushd(SRC_A);
            prog[2] = pushd(SRC_A);
         end
         OPC_UMPLUS: begin
            prog[0] = popd(1'b0);
            prog[1] = popd(1'b1);
            prog[2] = pushd(SRC_SUMLO);
            prog[3] = pushd(SRC_SUMHI);
         end
         OPC_NAND: begin
            prog[0] = popd(1'b0);
            prog[1] = popd(1'b1);
            prog[2] = pushd(SRC_NAND);
         end
         OPC_ZLESS: begin
            prog[0] = popd(1'b0);
            prog[1] = pushd(SRC_SIGN);
         end
         OPC_TOR: begin
            prog[0] = popd(1'b0);
            prog[1] = pushr(SRC_A);
         end
         OPC_RFROM: begin
            prog[0] = popr();
            prog[1] = pushd(SRC_A);
         end
         OPC_NEXT: begin
            prog[0] = simple(K_RDOP);
            prog[1] = popr();
            prog[2] = mk(K_PUSHR, SRC_DEC, 1'b0, 1'b1, PS_PC1, 1'b0);
            prog[3] = endp(PS_NEXT);
         end
         OPC_BRANCH: begin
            prog[0] = simple(K_RDOP);
            prog[1] = endp(PS_T);
         end
         OPC_ZBR: begin
            prog[0] = popd(1'b0);
            prog[1] = simple(K_RDOP);
            prog[2] = endp(PS_ZB);
         end
         OPC_EXEC: begin
            prog[0] = pushr(SRC_PC1);
            prog[1] = popd(1'b0);
            prog[2] = endp(PS_A);
         end
         OPC_TX: begin
            prog[0] = popd(1'b0);
            prog[1] = mk(K_END, SRC_A, 1'b0, 1'b0, PS_PC1, 1'b1);
         end
         OPC_RX: begin
            prog[0] = pushd(SRC_RX);
            prog[1] = pushd(SRC_ONES);
         end
         CLS_CALL: begin
            prog[0] = pushd(SRC_W);
            prog[1] = pushr(SRC_PC1);
            prog[2] = popd(1'b0);
            prog[3] = endp(PS_A);
         end
         CLS_START: begin
            prog[0] = simple(K_CPSP);
            prog[1] = simple(K_CPRP);
            prog[2] = pushr(SRC_MEMW);
            prog[3] = endp(PS_START);
         end
         default: begin
         end
      endcase
      return prog[idx];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/forth_stack_machine_core.sv @@
// ---------------------------------------------------------------------------
// forth_stack_machine_core
// 16-bit Forth machine; both stacks and their pointers live in word memory.
// ---------------------------------------------------------------------------
//  channel  ports              direction  beat
//  req      req_valid/ready    in         operation, address, value, rx
//  rsp      rsp_valid/ready    out        read data, tx, run state, pc
//
//  A step is a fetch plus a micro-program of stack pushes, pops, operand
//  reads and stores, run one at a time over the single memory port.
//  Synchronous reset clears pc, run state and control; memory is not cleared.
//  A finished beat waits in the output register; the next request is taken
//  meanwhile, the one after it waits until rsp_ready.
// ---------------------------------------------------------------------------
`default_nettype none

module forth_stack_machine_core #(
   parameter int unsigned MEM_WORDS = fsmc_pkg::MEM_WORDS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire fsmc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output fsmc_pkg::rsp_type      rsp_data
);
   import fsmc_pkg::*;

   localparam logic [16:0] MemEnd  = 17'(MEM_WORDS);
   localparam logic [15:0] MemWord = MemEnd[15:0];

   main_state_type state_ff, state_in;

   logic [15:0] pc_ff, a_ff, b_ff, t_ff, w_ff;
   logic [1:0]  run_ff;
   logic [4:0]  cls_ff;
   logic [2:0]  uidx_ff;
   logic [7:0]  rx_ff;
   logic        eof_ff;
   logic [15:0] rdv_ff;
   logic        tx_ff;
   logic [7:0]  txb_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   mem_req_type main_mreq, stk_mreq, mreq;
   stk_req_type sreq;
   stk_rsp_type srsp;
   logic [15:0] rdata;

   uop_type     uop;
   logic        skip;
   logic        stk_kind;
   logic [16:0] sum, pc1, pc2, np;
   logic [15:0] src_val;

   assign mreq = stk_mreq.en ? stk_mreq : main_mreq;

   fsmc_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
      .clock (clock),
      .mreq  (mreq),
      .rdata (rdata)
   );

   fsmc_stack u_stack (
      .clock (clock),
      .reset (reset),
      .sreq  (sreq),
      .rdata (rdata),
      .mreq  (stk_mreq),
      .srsp  (srsp)
   );

   assign uop      = uop_at(cls_ff, uidx_ff);
   assign skip     = uop.cond_nz && (a_ff == 16'd0);
   assign stk_kind = (uop.kind == K_PUSHD) || (uop.kind == K_PUSHR) ||
                     (uop.kind == K_POPD)  || (uop.kind == K_POPR);
   assign sum      = {1'b0, a_ff} + {1'b0, b_ff};
   assign pc1      = {1'b0, pc_ff} + 17'd1;
   assign pc2      = {1'b0, pc_ff} + 17'd2;

   always_comb begin
      case (uop.src)
         SRC_A:     src_val = a_ff;
         SRC_B:     src_val = b_ff;
         SRC_T:     src_val = t_ff;
         SRC_W:     src_val = w_ff;
         SRC_SUMLO: src_val = sum[15:0];
         SRC_SUMHI: src_val = {15'd0, sum[16]};
         SRC_NAND:  src_val = ~(a_ff & b_ff);
         SRC_SIGN:  src_val = ((a_ff & SIGN_BIT) != 16'd0) ? ALL_ONES : 16'd0;
         SRC_RX:    src_val = eof_ff ? ALL_ONES : {8'd0, rx_ff};
         SRC_ONES:  src_val = ALL_ONES;
         SRC_PC1:   src_val = pc1[15:0];
         SRC_DEC:   src_val = a_ff - 16'd1;
         SRC_MEMW:  src_val = MemWord;
         default:   src_val = a_ff;
      endcase
   end

   always_comb begin
      case (uop.pcsel)
         PS_PC1:   np = pc1;
         PS_PC2:   np = pc2;
         PS_A:     np = {1'b0, a_ff};
         PS_T:     np = {1'b0, t_ff};
         PS_NEXT:  np = (a_ff == 16'd0) ? pc2 : {1'b0, t_ff};
         PS_ZB:    np = (a_ff == 16'd0) ? {1'b0, t_ff} : pc2;
         PS_START: np = {1'b0, t_ff};
         default:  np = {1'b0, pc_ff};
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         M_IDLE: begin
            if (req_valid) begin
               case (req_data.operation)
                  OP_WRITE: state_in = M_DONE;
                  OP_READ:  state_in = M_READ;
                  OP_START: state_in = M_UOP;
                  OP_STEP:  state_in = (run_ff == RUN_GO) ? M_FETCH : M_DONE;
                  default:  state_in = M_DONE;
               endcase
            end
         end
         M_READ:   state_in = M_DONE;
         M_FETCH:  state_in = M_DECODE;
         M_DECODE: state_in = M_UOP;
         M_UOP: begin
            case (uop.kind)
               K_END:   state_in = M_DONE;
               K_STORE: state_in = M_UOP;
               K_PUSHD, K_PUSHR, K_POPD, K_POPR:
                  state_in = skip ? M_UOP : M_STKW;
               default: state_in = M_RDW;
            endcase
         end
         M_STKW: if (srsp.done) state_in = M_UOP;
         M_RDW:  state_in = M_UOP;
         M_DONE: if (!rsp_valid_ff || rsp_ready) state_in = M_IDLE;
         default: state_in = M_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = (state_ff == M_IDLE);
      main_mreq  = '0;
      sreq       = '0;
      sreq.value = src_val;
      case (state_ff)
         M_IDLE: begin
            if (req_valid && (req_data.operation == OP_WRITE ||
                              req_data.operation == OP_READ)) begin
               main_mreq.en    = 1'b1;
               main_mreq.we    = (req_data.operation == OP_WRITE);
               main_mreq.addr  = {3'd0, req_data.address};
               main_mreq.wdata = req_data.write_value;
            end
         end
         M_FETCH: begin
            main_mreq.en   = 1'b1;
            main_mreq.addr = pc_ff;
         end
         M_UOP: begin
            if (stk_kind) begin
               sreq.go  = !skip;
               sreq.rs  = (uop.kind == K_PUSHR) || (uop.kind == K_POPR);
               sreq.pop = (uop.kind == K_POPD) || (uop.kind == K_POPR);
            end
            case (uop.kind)
               K_RDOP: begin
                  main_mreq.en   = 1'b1;
                  main_mreq.addr = pc1[15:0];
               end
               K_LOAD: begin
                  main_mreq.en   = 1'b1;
                  main_mreq.addr = a_ff;
               end
               K_STORE: begin
                  main_mreq.en    = 1'b1;
                  main_mreq.we    = 1'b1;
                  main_mreq.addr  = a_ff;
                  main_mreq.wdata = b_ff;
               end
               K_CPSP: begin
                  main_mreq.en   = 1'b1;
                  main_mreq.addr = CELL_SP0;
               end
               K_CPRP: begin
                  main_mreq.en   = 1'b1;
                  main_mreq.addr = CELL_RP0;
               end
               default: begin
               end
            endcase
         end
         M_RDW: begin
            if (uop.kind == K_CPSP || uop.kind == K_CPRP) begin
               main_mreq.en    = 1'b1;
               main_mreq.we    = 1'b1;
               main_mreq.addr  = (uop.kind == K_CPSP) ? CELL_SP : CELL_RP;
               main_mreq.wdata = rdata;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= M_IDLE;
         pc_ff        <= '0;
         run_ff       <= RUN_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == M_UOP && uop.kind == K_END) begin
            if (uop.pcsel == PS_HALT) begin
               run_ff <= RUN_HALT;
            end else begin
               pc_ff  <= np[15:0];
               run_ff <= (np >= MemEnd) ? RUN_END : RUN_GO;
            end
         end
         if (state_ff == M_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         M_IDLE: begin
            if (req_valid) begin
               rx_ff   <= req_data.rx_byte;
               eof_ff  <= req_data.rx_eof;
               t_ff    <= {3'd0, req_data.address};
               rdv_ff  <= '0;
               tx_ff   <= 1'b0;
               txb_ff  <= '0;
               uidx_ff <= '0;
               cls_ff  <= CLS_START;
            end
         end
         M_READ: rdv_ff <= rdata;
         M_DECODE: begin
            w_ff    <= rdata;
            cls_ff  <= opc_class(rdata);
            uidx_ff <= '0;
         end
         M_UOP: begin
            if (uop.kind == K_STORE || (stk_kind && skip)) begin
               uidx_ff <= uidx_ff + 3'd1;
            end
            if (uop.kind == K_END && uop.tx) begin
               tx_ff  <= 1'b1;
               txb_ff <= a_ff[7:0];
            end
         end
         M_STKW: begin
            if (srsp.done) begin
               uidx_ff <= uidx_ff + 3'd1;
               if (uop.kind == K_POPD || uop.kind == K_POPR) begin
                  if (uop.dst_b) begin
                     b_ff <= srsp.data;
                  end else begin
                     a_ff <= srsp.data;
                  end
               end
            end
         end
         M_RDW: begin
            uidx_ff <= uidx_ff + 3'd1;
            if (uop.kind == K_RDOP) t_ff <= rdata;
            if (uop.kind == K_LOAD) a_ff <= rdata;
         end
         M_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_ff.read_data       <= rdv_ff;
               rsp_ff.tx_valid        <= tx_ff;
               rsp_ff.tx_byte         <= txb_ff;
               rsp_ff.run_state       <= run_ff;
               rsp_ff.program_counter <= pc_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(stk_mreq.en && main_mreq.en))
      else $error("memory port driven by both sequencers");

   a_running_pc: assert property (@(posedge clock) disable iff (reset)
      (run_ff == RUN_GO) |-> ({1'b0, pc_ff} < MemEnd))
      else $error("running with pc past memory end");

   a_stack_done: assert property (@(posedge clock) disable iff (reset)
      srsp.done |-> (state_ff == M_STKW))
      else $error("stack sequencer finished outside a stack wait");

endmodule

`default_nettype wire

@@ hw/rtl/fsmc_mem.sv @@
// ---------------------------------------------------------------------------
// fsmc_mem
// Single-port word memory, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module fsmc_mem #(
   parameter int unsigned MEM_WORDS = fsmc_pkg::MEM_WORDS_DEF
) (
   input  wire logic                clock,
   input  wire fsmc_pkg::mem_req_type mreq,
   output logic [15:0]              rdata
);
   import fsmc_pkg::*;

   localparam int unsigned AW = $clog2(MEM_WORDS);

   logic [15:0] mem [MEM_WORDS];

   always_ff @(posedge clock) begin
      if (mreq.en) begin
         if (mreq.we) begin
            mem[mreq.addr[AW-1:0]] <= mreq.wdata;
         end
         rdata <= mem[mreq.addr[AW-1:0]];
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/fsmc_stack.sv @@
// ---------------------------------------------------------------------------
// fsmc_stack
// Push/pop sequencer: pointer read, then cell access and pointer update.
// ---------------------------------------------------------------------------
`default_nettype none

module fsmc_stack (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fsmc_pkg::stk_req_type sreq,
   input  wire logic [15:0]           rdata,
   output fsmc_pkg::mem_req_type      mreq,
   output fsmc_pkg::stk_rsp_type      srsp
);
   import fsmc_pkg::*;

   stk_state_type state_ff, state_in;
   logic          rs_ff, pop_ff;
   logic [15:0]   val_ff;
   logic [15:0]   ptr_cell;
   logic [15:0]   nptr;

   assign ptr_cell = rs_ff ? CELL_RP : CELL_SP;
   // data stack grows up, return stack down
   assign nptr = (rs_ff == pop_ff) ? rdata + 16'd1 : rdata - 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && sreq.go) begin
         rs_ff  <= sreq.rs;
         pop_ff <= sreq.pop;
         val_ff <= sreq.value;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (sreq.go) state_in = S_P1;
         S_P1:   state_in = S_P2;
         S_P2:   state_in = S_P3;
         S_P3:   state_in = pop_ff ? S_P4 : S_IDLE;
         S_P4:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      mreq      = '0;
      srsp.done = 1'b0;
      srsp.data = rdata;
      case (state_ff)
         S_IDLE: begin
            if (sreq.go) begin
               mreq.en   = 1'b1;
               mreq.addr = sreq.rs ? CELL_RP : CELL_SP;
            end
         end
         S_P1: begin
            mreq.en = 1'b1;
            mreq.we = 1'b1;
            if (pop_ff) begin
               mreq.addr  = ptr_cell;
               mreq.wdata = nptr;
            end else begin
               mreq.addr  = rdata;
               mreq.wdata = val_ff;
            end
         end
         S_P2: begin
            mreq.en   = 1'b1;
            mreq.addr = ptr_cell;
         end
         S_P3: begin
            mreq.en = 1'b1;
            if (pop_ff) begin
               mreq.addr = rdata;
            end else begin
               mreq.we    = 1'b1;
               mreq.addr  = ptr_cell;
               mreq.wdata = nptr;
               srsp.done  = 1'b1;
            end
         end
         S_P4: begin
            srsp.done = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

@@ dv/forth_stack_machine_core_tb.sv @@
// ---------------------------------------------------------------------------
// forth_stack_machine_core_tb
// Self-checking bench for the 16-bit Forth stack machine core. After a step
// before any start, the whole word memory is loaded; then short directed runs
// and many random programs are started and single-stepped. A built-in machine
// model predicts each response beat; the monitor compares every field in order.
// ---------------------------------------------------------------------------
`default_nettype none

module forth_stack_machine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fsmc_pkg::*;

   localparam int unsigned WORDS = MEM_WORDS_DEF;

   typedef struct {
      req_type beat;
      bit      hold;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   pending_type pending_reqs[$];
   rsp_type     expected_rsps[$];
   int          errors = 0;
   int          n_accepted = 0;
   int          n_total = 0;
   bit          gen_done = 0;
   bit          req_fire = 0;

   // machine state mirror
   logic [15:0] mem_model[WORDS];
   logic [15:0] pc_model = '0;
   logic [1:0]  run_model = RUN_IDLE;

   forth_stack_machine_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   function automatic logic [15:0] rd(logic [31:0] a);
      return mem_model[a[12:0]];
   endfunction

   function automatic void wr(logic [31:0] a, logic [31:0] v);
      mem_model[a[12:0]] = v[15:0];
   endfunction

   function automatic void push_data(logic [31:0] v);
      wr(rd(CELL_SP), v);
      wr(CELL_SP, rd(CELL_SP) + 32'd1);
   endfunction

   function automatic logic [15:0] pop_data();
      wr(CELL_SP, rd(CELL_SP) + 32'hFFFF);
      return rd(rd(CELL_SP));
   endfunction

   function automatic void push_ret(logic [31:0] v);
      wr(rd(CELL_RP), v);
      wr(CELL_RP, rd(CELL_RP) + 32'hFFFF);
   endfunction

   function automatic logic [15:0] pop_ret();
      wr(CELL_RP, rd(CELL_RP) + 32'd1);
      return rd(rd(CELL_RP));
   endfunction

   function automatic void jump(logic [31:0] np);
      pc_model = np[15:0];
      if (np >= WORDS) run_model = RUN_END;
   endfunction

   function automatic rsp_type machine_apply(req_type r);
      rsp_type     o;
      logic [31:0] p, a, b, t;
      logic [15:0] w;
      o = '0;
      case (r.operation)
         OP_WRITE: wr(r.address, r.write_value);
         OP_READ:  o.read_data = rd(r.address);
         OP_START: begin
            wr(CELL_SP, rd(CELL_SP0));
            wr(CELL_RP, rd(CELL_RP0));
            push_ret(WORDS);
            run_model = RUN_GO;
            jump(r.address);
         end
         default: begin
            if (run_model == RUN_GO) begin
               p = pc_model;
               w = rd(p);
               if (w >= 16'd21) begin
                  push_data(w); push_ret(p + 1); jump(pop_data());
               end else begin
                  case (w[4:0])
                     OPC_NOP:   jump(p + 1);
                     OPC_HALT:  run_model = RUN_HALT;
                     OPC_LIT:   begin push_data(rd(p + 1)); jump(p + 2); end
                     OPC_EXIT:  jump(pop_ret());
                     OPC_LOAD:  begin a = pop_data(); push_data(rd(a)); jump(p + 1); end
                     OPC_STORE: begin a = pop_data(); b = pop_data(); wr(a, b); jump(p + 1); end
                     OPC_DROP:  begin a = pop_data(); jump(p + 1); end
                     OPC_OVER:  begin
                        a = pop_data(); b = pop_data();
                        push_data(b); push_data(a); push_data(b); jump(p + 1);
                     end
                     OPC_SWAP:  begin
                        a = pop_data(); b = pop_data();
                        push_data(a); push_data(b); jump(p + 1);
                     end
                     OPC_DUP:   begin a = pop_data(); push_data(a); push_data(a); jump(p + 1); end
                     OPC_UMPLUS: begin
                        a = pop_data(); b = pop_data(); t = a + b;
                        push_data(t & 32'hFFFF); push_data(t >> 16); jump(p + 1);
                     end
                     OPC_NAND:  begin
                        a = pop_data(); b = pop_data();
                        push_data(~(a & b) & 32'hFFFF); jump(p + 1);
                     end
                     OPC_ZLESS: begin
                        a = pop_data();
                        push_data((a & SIGN_BIT) != 0 ? ALL_ONES : 16'd0); jump(p + 1);
                     end
                     OPC_TOR:   begin a = pop_data(); push_ret(a); jump(p + 1); end
                     OPC_RFROM: begin a = pop_ret(); push_data(a); jump(p + 1); end
                     OPC_NEXT:  begin
                        t = rd(p + 1);
                        a = pop_ret();
                        if (a == 0) jump(p + 2);
                        else begin push_ret(a - 1); jump(t); end
                     end
                     OPC_BRANCH: jump(rd(p + 1));
                     OPC_ZBR:   begin
                        a = pop_data(); t = rd(p + 1);
                        if (a == 0) jump(t); else jump(p + 2);
                     end
                     OPC_EXEC:  begin push_ret(p + 1); jump(pop_data()); end
                     OPC_TX:    begin
                        a = pop_data(); o.tx_valid = 1'b1; o.tx_byte = a[7:0]; jump(p + 1);
                     end
                     default:   begin
                        push_data(r.rx_eof ? ALL_ONES : {8'd0, r.rx_byte});
                        push_data(ALL_ONES); jump(p + 1);
                     end
                  endcase
               end
            end
         end
      endcase
      o.run_state = run_model;
      o.program_counter = pc_model;
      return o;
   endfunction

   // ---- stimulus ----
   task automatic add_beat(op_type op, int unsigned addr, int unsigned val, bit hold = 0);
      pending_type e;
      e.beat.operation   = op;
      e.beat.address     = addr[12:0];
      e.beat.write_value = val[15:0];
      e.beat.rx_byte     = $urandom_range(255);
      e.beat.rx_eof      = ($urandom_range(3) == 0);
      e.hold = hold;
      pending_reqs.push_back(e);
   endtask

   function automatic int unsigned program_word(int unsigned base, int unsigned len);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 2) return OPC_HALT;
      if (r < 75) return $urandom_range(20);
      if (r < 87) return base + $urandom_range(len - 1);
      return $urandom_range(16'hFFFF);
   endfunction

   task automatic random_program(bit hold);
      int unsigned base, len, sp, rp, steps;
      base = $urandom_range(64, WORDS - 40);
      len = $urandom_range(4, 24);
      sp = ($urandom_range(9) == 0) ? $urandom_range(30, 36) : $urandom_range(40, WORDS - 1);
      rp = ($urandom_range(9) == 0) ? $urandom_range(32, 40) : $urandom_range(40, WORDS - 1);
      add_beat(OP_WRITE, CELL_SP0, sp, hold);
      add_beat(OP_WRITE, CELL_RP0, rp);
      for (int i = 0; i < len; i++) add_beat(OP_WRITE, base + i, program_word(base, len));
      add_beat(OP_START, base, $urandom);
      steps = $urandom_range(1, 40);
      for (int i = 0; i < steps; i++) add_beat(OP_STEP, $urandom, $urandom);
      if ($urandom_range(3) == 0) add_beat(OP_READ, $urandom, $urandom);
   endtask

   task automatic directed_run(int unsigned at, int unsigned w0, int unsigned w1, int n);
      add_beat(OP_WRITE, at, w0);
      add_beat(OP_WRITE, (at + 1) % WORDS, w1);
      add_beat(OP_START, at, 0);
      for (int i = 0; i < n; i++) add_beat(OP_STEP, 0, 0);
   endtask

   initial begin
      int unsigned fill_count;
      // step before any start: idle, no memory touched
      add_beat(OP_STEP, 0, 0);
      for (int unsigned a = 0; a < WORDS; a++)
         add_beat(OP_WRITE, a, ($urandom_range(1) == 0) ? $urandom_range(30) : $urandom);
      add_beat(OP_WRITE, CELL_SP0, 200);
      add_beat(OP_WRITE, CELL_RP0, 7000);
      fill_count = pending_reqs.size();
      add_beat(OP_READ, 0, 0);
      add_beat(OP_READ, WORDS - 1, 16'hFFFF);
      directed_run(WORDS - 1, OPC_NOP, 0, 2);        // pc runs off the end
      directed_run(WORDS - 1, OPC_LIT, 5, 1);        // operand wraps to cell 0
      directed_run(300, OPC_HALT, 0, 2);
      directed_run(310, OPC_BRANCH, 16'hFFFF, 1);    // pc shown as 0xFFFF
      directed_run(320, OPC_RX, OPC_TX, 3);
      directed_run(330, OPC_NEXT, 330, 2);           // count taken from return stack
      add_beat(OP_START, 340, 0);                    // restart while running
      n_total = fill_count;
      for (int k = 0; pending_reqs.size() < fill_count + 2000; k++) begin
         if ($urandom_range(4) == 0) begin
            add_beat(op_type'($urandom_range(3)), $urandom, $urandom);
         end else begin
            random_program(k % 10 == 5);
         end
      end
      n_total = pending_reqs.size() - fill_count;
      gen_done = 1;
   end

   function automatic int idle_pct(bit sender);
      int body;
      body = n_accepted - (WORDS + 3);
      if (body < 0) return 0;
      if (body < n_total / 3) return sender ? 23 : 54;
      if (body < 2 * n_total / 3) return sender ? 54 : 23;
      return 0;
   endfunction

   // ---- driver ----
   always @(negedge clock) begin
      if (!reset && gen_done) begin
         rsp_ready <= ($urandom_range(99) >= idle_pct(0));
         if (!req_valid || req_fire) begin
            req_fire = 0;
            if (pending_reqs.size() > 0 &&
                !(pending_reqs[0].hold && expected_rsps.size() > 0) &&
                $urandom_range(99) >= idle_pct(1)) begin
               req_data  <= pending_reqs.pop_front().beat;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---- monitor ----
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(machine_apply(req_data));
            n_accepted++;
            req_fire = 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response beat with nothing expected");
               errors++;
            end else begin
               exp_r = expected_rsps.pop_front();
               if (rsp_data.read_data !== exp_r.read_data) begin
                  $error("read_data exp %h got %h", exp_r.read_data, rsp_data.read_data);
                  errors++;
               end
               if (rsp_data.tx_valid !== exp_r.tx_valid) begin
                  $error("tx_valid exp %b got %b", exp_r.tx_valid, rsp_data.tx_valid);
                  errors++;
               end
               if (rsp_data.tx_byte !== exp_r.tx_byte) begin
                  $error("tx_byte exp %h got %h", exp_r.tx_byte, rsp_data.tx_byte);
                  errors++;
               end
               if (rsp_data.run_state !== exp_r.run_state) begin
                  $error("run_state exp %0d got %0d", exp_r.run_state, rsp_data.run_state);
                  errors++;
               end
               if (rsp_data.program_counter !== exp_r.program_counter) begin
                  $error("program_counter exp %h got %h",
                         exp_r.program_counter, rsp_data.program_counter);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (gen_done);
      do @(posedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0);
      repeat (60) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
